// File: rtl/core/bbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and constants of the bracket balance checker: payload structs,
// the command that travels from the classifier to the stack engine, and the
// fault codes.
// ----------------------------------------------------------------------------
package bbc_pkg;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_expr;
    } in_item_t;

    typedef struct packed {
        logic       balanced;
        logic [2:0] fault_kind;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_OPEN  = 2'd1,
        OP_CLOSE = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        FAULT_NONE        = 3'd0,
        FAULT_CLOSE_EMPTY = 3'd1,
        FAULT_MISMATCH    = 3'd2,
        FAULT_LEFT_OPEN   = 3'd3,
        FAULT_OVERFLOW    = 3'd4
    } fault_t;

    // bracket type codes kept on the stack
    localparam logic [1:0] BR_ROUND  = 2'd0;
    localparam logic [1:0] BR_SQUARE = 2'd1;
    localparam logic [1:0] BR_CURLY  = 2'd2;

    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;
    localparam logic [7:0] CHAR_LBRACK = 8'h5B;
    localparam logic [7:0] CHAR_RBRACK = 8'h5D;
    localparam logic [7:0] CHAR_LBRACE = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE = 8'h7D;

    typedef struct packed {
        op_t        op;
        logic [1:0] kind;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage
`default_nettype wire

// File: rtl/core/bracket_balance_checker_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bracket_balance_checker_core
// Checks that (), [] and {} nest and match over a byte stream, one result
// per expression on its marked last byte.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the queue is not full, set by the stack
//   engine doing one push or pop a cycle with the top entry and the entry below
//   it held in registers. The result is registered and loads on the last byte.
// Reset: synchronous, active low; clears queue, count, fault and result valid.
//   Stack memory is not cleared and needs no clearing pass.
module bracket_balance_checker_core
    import bbc_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    q_status_t q_status;
    logic      q_push, q_pop, head_valid;
    cmd_t      q_cmd, head_cmd;

    bbc_front u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_status (q_status),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    bbc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .status     (q_status),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (q_pop)
    );

    bbc_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (head_valid),
        .cmd       (head_cmd),
        .cmd_ready (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // balanced flag and fault code must agree
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.balanced == (m_data.fault_kind == FAULT_NONE)))
        else $error("balanced flag disagrees with fault code");

    // only defined fault codes reach the result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.fault_kind <= FAULT_OVERFLOW))
        else $error("undefined fault code on result");

    // queue cannot be both full and empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_status.full && q_status.empty))
        else $error("queue status inconsistent");

    // a full queue stalls the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.full |-> !s_ready)
        else $error("input ready while queue full");

endmodule
`default_nettype wire

// File: rtl/core/bbc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_front
// Input side: decodes each byte into a push, a pop or nothing, and forwards
// only bytes that matter (brackets and the end marker) to the command queue.
// ----------------------------------------------------------------------------
module bbc_front
    import bbc_pkg::*;
(
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    input  wire q_status_t q_status,
    output logic           q_push,
    output cmd_t           q_cmd
);

    logic keep;

    always_comb begin
        q_cmd.last = s_data.end_of_expr;
        q_cmd.op   = OP_NONE;
        q_cmd.kind = BR_ROUND;
        unique case (s_data.char_byte)
            CHAR_LPAREN: begin q_cmd.op = OP_OPEN;  q_cmd.kind = BR_ROUND;  end
            CHAR_LBRACK: begin q_cmd.op = OP_OPEN;  q_cmd.kind = BR_SQUARE; end
            CHAR_LBRACE: begin q_cmd.op = OP_OPEN;  q_cmd.kind = BR_CURLY;  end
            CHAR_RPAREN: begin q_cmd.op = OP_CLOSE; q_cmd.kind = BR_ROUND;  end
            CHAR_RBRACK: begin q_cmd.op = OP_CLOSE; q_cmd.kind = BR_SQUARE; end
            CHAR_RBRACE: begin q_cmd.op = OP_CLOSE; q_cmd.kind = BR_CURLY;  end
            default: begin
                q_cmd.op   = OP_NONE;
                q_cmd.kind = BR_ROUND;
            end
        endcase
    end

    // plain text bytes in the middle of an expression are dropped here
    assign keep    = (q_cmd.op != OP_NONE) || s_data.end_of_expr;
    assign s_ready = !q_status.full;
    assign q_push  = s_valid && !q_status.full && keep;

endmodule
`default_nettype wire

// File: rtl/core/bbc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_queue
// Two-entry command queue between the classifier and the stack engine.
// ----------------------------------------------------------------------------
module bbc_queue
    import bbc_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire cmd_t  push_cmd,
    output q_status_t  status,
    output logic       head_valid,
    output cmd_t       head_cmd,
    input  wire logic  pop
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign head_valid   = !status.empty;
    assign head_cmd     = slot_reg[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/bbc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_back
// Stack engine: runs one push or pop a cycle against the bracket stack (a last
// byte waits until the result register is free), keeps the sticky fault, and
// loads the result register on the last byte.
module bbc_back
    import bbc_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      cmd_valid,
    input  wire cmd_t      cmd,
    output logic           cmd_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    // top of stack lives in tos_reg; entries below it live in the memory
    logic [1:0]    stack_mem [DEPTH];
    logic [1:0]    tos_reg, tos_next;
    logic [1:0]    rd_reg;
    logic          byp_reg;
    logic [1:0]    byp_data_reg;
    logic [1:0]    below;
    logic [CW-1:0] count_reg, count_next, count_step;
    fault_t        fault_reg, fault_next, fault_step, fault_final;
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_data_reg;
    logic          out_free, fire, load_out, mem_wr, do_byp;
    logic [CW-1:0] wr_sum, rd_sum;
    logic [AW-1:0] wr_addr, rd_addr;

    assign out_free  = !out_valid_reg || m_ready;
    assign cmd_ready = !cmd.last || out_free;
    assign fire      = cmd_valid && cmd_ready;
    assign below     = byp_reg ? byp_data_reg : rd_reg;

    always_comb begin
        count_step = count_reg;
        fault_step = fault_reg;
        tos_next   = tos_reg;
        mem_wr     = 1'b0;
        do_byp     = 1'b0;
        if (fire && (fault_reg == FAULT_NONE)) begin
            case (cmd.op)
                OP_OPEN: begin
                    if (count_reg == FULL_COUNT) begin
                        fault_step = FAULT_OVERFLOW;
                    end else begin
                        mem_wr     = (count_reg != '0);
                        do_byp     = 1'b1;
                        tos_next   = cmd.kind;
                        count_step = count_reg + CW'(1);
                    end
                end
                OP_CLOSE: begin
                    if (count_reg == '0) begin
                        fault_step = FAULT_CLOSE_EMPTY;
                    end else begin
                        count_step = count_reg - CW'(1);
                        tos_next   = below;
                        if (tos_reg != cmd.kind) begin
                            fault_step = FAULT_MISMATCH;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        fault_final = fault_step;
        if ((fault_step == FAULT_NONE) && (count_step != '0)) begin
            fault_final = FAULT_LEFT_OPEN;
        end
        load_out = fire && cmd.last;
        if (load_out) begin
            count_next = '0;
            fault_next = FAULT_NONE;
        end else begin
            count_next = count_step;
            fault_next = fault_step;
        end
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // old top goes to slot count-1; prefetch slot count_next-2 as the next below
    assign wr_sum  = count_reg - CW'(1);
    assign rd_sum  = count_next - CW'(2);
    assign wr_addr = wr_sum[AW-1:0];
    assign rd_addr = rd_sum[AW-1:0];

    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            stack_mem[wr_addr] <= tos_reg;
        end
        rd_reg       <= stack_mem[rd_addr];
        byp_data_reg <= tos_reg;
        tos_reg      <= tos_next;
        if (load_out) begin
            out_data_reg.balanced   <= (fault_final == FAULT_NONE);
            out_data_reg.fault_kind <= fault_final;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            fault_reg     <= FAULT_NONE;
            out_valid_reg <= 1'b0;
            byp_reg       <= 1'b0;
        end else begin
            count_reg     <= count_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
            byp_reg       <= do_byp;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
`default_nettype wire
